[rtl/uart_line_receive_fifo_macros.svh]
// -----------------------------------------------------------------------------
// uart_line_receive_fifo macros
// Assertion macros shared by the receive FIFO RTL.
// -----------------------------------------------------------------------------
`ifndef UART_LINE_RECEIVE_FIFO_MACROS_SVH
`define UART_LINE_RECEIVE_FIFO_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property that must hold at every clock edge out of reset.
`define ULRF_ASSERT(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error(msg);

// Condition in this cycle implies a condition in the next cycle.
`define ULRF_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`else

`define ULRF_ASSERT(label, expr, msg)
`define ULRF_ASSERT_NEXT(label, pre, post, msg)

`endif

`endif

[rtl/ulrf_pkg.sv]
// -----------------------------------------------------------------------------
// ulrf_pkg
// Constants, command codes and stage types of the line receive FIFO.
// -----------------------------------------------------------------------------
package ulrf_pkg;

	localparam int FIFO_CAPACITY = 255;
	localparam int LINE_LIMIT    = 255;
	localparam int ADDR_W        = $clog2(FIFO_CAPACITY);

	localparam logic [7:0] CHAR_CR   = 8'h0D;
	localparam logic [7:0] CHAR_LF   = 8'h0A;
	localparam logic [7:0] PRINT_MIN = 8'h19;

	localparam logic [7:0] CAP8   = 8'(FIFO_CAPACITY);
	localparam logic [7:0] LIMIT8 = 8'(LINE_LIMIT);

	typedef enum logic [1:0] {
		CMD_RECEIVE = 2'd0,
		CMD_POP     = 2'd1,
		CMD_FLUSH   = 2'd2
	} cmd_t;

	// what the store stage hands to the line stage
	typedef struct packed {
		logic       pop_ok;
		logic       pop_empty;
		logic       cr_stored;
		logic       clear;
		logic       ovf;
		logic [7:0] fill;
	} stage_t;

	typedef struct packed {
		logic [7:0] popped_byte;
		logic       popped_valid;
		logic       pop_was_empty;
		logic       overflow_flush;
		logic [7:0] fill_level;
		logic       byte_ready;
		logic [7:0] lines_pending;
		logic       line_ready;
		logic       kept_in_line;
		logic       line_done;
		logic [7:0] line_length;
	} result_t;

endpackage

[rtl/uart_line_receive_fifo.sv]
// -----------------------------------------------------------------------------
// uart_line_receive_fifo
// Receive byte FIFO with pending line count and pop-side line assembler.
// -----------------------------------------------------------------------------
// One word in, one result word out, at a sustained rate of one word per clock while out_stall is low.
// A word passes two register stages: the first updates the ring pointers
// and fill count and reads the oldest byte from the 255-byte store (registered
// read); the second applies the popped byte to the line count and line
// assembler and loads the result register. out_valid rises when the word
// moves from stage 1 into the result register, which can wait on out_stall;
// the extra stage is set by the store's registered read port. Line feeds are
// dropped on receive; a receive that brings the fill level to capacity flushes
// everything and flags overflow_flush. Popping an empty FIFO changes nothing
// and returns pop_was_empty. Command code 3 is a no-op that still reports
// status. The store is not cleared after reset; only written slots are read.
// in_stall follows out_stall only while both stages are full.
// -----------------------------------------------------------------------------
`include "uart_line_receive_fifo_macros.svh"

module uart_line_receive_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	// input channel
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [1:0]           command,
	input  logic [7:0]           rx_byte,
	// result channel
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [7:0]           popped_byte,
	output logic                 popped_valid,
	output logic                 pop_was_empty,
	output logic                 overflow_flush,
	output logic [7:0]           fill_level,
	output logic                 byte_ready,
	output logic [7:0]           lines_pending,
	output logic                 line_ready,
	output logic                 kept_in_line,
	output logic                 line_done,
	output logic [7:0]           line_length
);

	import ulrf_pkg::*;

	// ring buffer storage, no reset
	logic [7:0] byte_store [FIFO_CAPACITY];

	// store-side state
	logic [ADDR_W-1:0] head_q;
	logic [7:0]        fill_q;

	// line-side state, advanced in word order at the second stage
	logic [7:0] line_count_q;
	logic [7:0] line_pos_q;

	// stage 1 and result register
	logic        s1_valid_q;
	stage_t      s1_info_s1;
	logic [7:0]  rd_data_s1;
	logic        out_valid_q;
	result_t     res_q;

	logic in_acc;
	logic s1_adv;

	// ---------------------------------------------------------------
	// Handshake: the result register frees when empty or taken; stage 1
	// moves forward with it and takes a new word in the same cycle.
	// ---------------------------------------------------------------
	assign s1_adv   = s1_valid_q && (!out_valid_q || !out_stall);
	assign in_stall = s1_valid_q && out_valid_q && out_stall;
	assign in_acc   = in_valid && !in_stall;

	// ---------------------------------------------------------------
	// Stage 0: command decode, pointers, fill count.
	// ---------------------------------------------------------------
	logic              is_rcv, is_pop, is_flush;
	logic              store_en, pop_ok, ovf;
	logic [7:0]        fill_inc;
	logic [8:0]        slot_sum;
	logic [ADDR_W-1:0] wr_addr;
	logic [ADDR_W-1:0] head_inc;
	logic [ADDR_W-1:0] head_nxt;
	logic [7:0]        fill_nxt;
	stage_t            s0_info;

	always_comb begin
		is_rcv   = 1'b0;
		is_pop   = 1'b0;
		is_flush = 1'b0;
		unique case (command)
			CMD_RECEIVE: is_rcv   = 1'b1;
			CMD_POP:     is_pop   = 1'b1;
			CMD_FLUSH:   is_flush = 1'b1;
			default:     ;
		endcase
	end

	always_comb begin
		store_en = is_rcv && (fill_q < CAP8) && (rx_byte != CHAR_LF);
		fill_inc = fill_q + 8'(store_en);
		ovf      = is_rcv && (fill_inc >= CAP8);
		pop_ok   = is_pop && (fill_q != 8'd0);

		// write slot is head + fill, wrapped once
		slot_sum = 9'(head_q) + 9'(fill_q);
		if (slot_sum >= 9'(FIFO_CAPACITY)) begin
			slot_sum = slot_sum - 9'(FIFO_CAPACITY);
		end
		wr_addr = ADDR_W'(slot_sum);

		if (9'(head_q) + 9'd1 >= 9'(FIFO_CAPACITY)) begin
			head_inc = '0;
		end else begin
			head_inc = head_q + ADDR_W'(1);
		end

		head_nxt = head_q;
		fill_nxt = fill_q;
		if (ovf || is_flush) begin
			head_nxt = '0;
			fill_nxt = 8'd0;
		end else if (store_en) begin
			fill_nxt = fill_inc;
		end else if (pop_ok) begin
			head_nxt = head_inc;
			fill_nxt = fill_q - 8'd1;
		end

		s0_info.pop_ok    = pop_ok;
		s0_info.pop_empty = is_pop && (fill_q == 8'd0);
		s0_info.cr_stored = store_en && (rx_byte == CHAR_CR);
		s0_info.clear     = ovf || is_flush;
		s0_info.ovf       = ovf;
		s0_info.fill      = fill_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q     <= '0;
			fill_q     <= 8'd0;
			s1_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				head_q <= head_nxt;
				fill_q <= fill_nxt;
			end
			if (in_acc) begin
				s1_valid_q <= 1'b1;
			end else if (s1_adv) begin
				s1_valid_q <= 1'b0;
			end
		end
	end

	// Store write and registered read of the oldest byte. A pop and a
	// write never share an edge, so the read sees every earlier write.
	always_ff @(posedge clk) begin
		if (in_acc && store_en) begin
			byte_store[wr_addr] <= rx_byte;
		end
		if (in_acc) begin
			rd_data_s1 <= byte_store[head_q];
			s1_info_s1 <= s0_info;
		end
	end

	// ---------------------------------------------------------------
	// Stage 1: line count and line assembler on the popped byte.
	// ---------------------------------------------------------------
	logic [7:0] pbyte;
	logic       is_cr, kept;
	logic [7:0] lpos_inc;
	logic [7:0] lcount_nxt;
	logic [7:0] lpos_nxt;
	result_t    res_nxt;

	always_comb begin
		pbyte    = s1_info_s1.pop_ok ? rd_data_s1 : 8'd0;
		is_cr    = s1_info_s1.pop_ok && (pbyte == CHAR_CR);
		kept     = s1_info_s1.pop_ok && (pbyte > PRINT_MIN) && (line_pos_q < LIMIT8);
		lpos_inc = line_pos_q + 8'(kept);

		if (s1_info_s1.clear) begin
			lcount_nxt = 8'd0;
		end else if (s1_info_s1.cr_stored) begin
			lcount_nxt = line_count_q + 8'd1;
		end else if (is_cr && (line_count_q != 8'd0)) begin
			lcount_nxt = line_count_q - 8'd1;
		end else begin
			lcount_nxt = line_count_q;
		end

		if (s1_info_s1.clear || is_cr) begin
			lpos_nxt = 8'd0;
		end else begin
			lpos_nxt = lpos_inc;
		end

		res_nxt.popped_byte    = pbyte;
		res_nxt.popped_valid   = s1_info_s1.pop_ok;
		res_nxt.pop_was_empty  = s1_info_s1.pop_empty;
		res_nxt.overflow_flush = s1_info_s1.ovf;
		res_nxt.fill_level     = s1_info_s1.fill;
		res_nxt.byte_ready     = (s1_info_s1.fill != 8'd0);
		res_nxt.lines_pending  = lcount_nxt;
		res_nxt.line_ready     = (lcount_nxt != 8'd0);
		res_nxt.kept_in_line   = kept;
		res_nxt.line_done      = is_cr;
		res_nxt.line_length    = s1_info_s1.clear ? 8'd0 : lpos_inc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_count_q <= 8'd0;
			line_pos_q   <= 8'd0;
			out_valid_q  <= 1'b0;
		end else begin
			if (s1_adv) begin
				line_count_q <= lcount_nxt;
				line_pos_q   <= lpos_nxt;
				out_valid_q  <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			res_q <= res_nxt;
		end
	end

	assign out_valid      = out_valid_q;
	assign popped_byte    = res_q.popped_byte;
	assign popped_valid   = res_q.popped_valid;
	assign pop_was_empty  = res_q.pop_was_empty;
	assign overflow_flush = res_q.overflow_flush;
	assign fill_level     = res_q.fill_level;
	assign byte_ready     = res_q.byte_ready;
	assign lines_pending  = res_q.lines_pending;
	assign line_ready     = res_q.line_ready;
	assign kept_in_line   = res_q.kept_in_line;
	assign line_done      = res_q.line_done;
	assign line_length    = res_q.line_length;

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
	`ULRF_ASSERT(a_fill_below_cap, fill_q < CAP8, "fill count reached capacity at rest")
	`ULRF_ASSERT(a_line_pos_limit, line_pos_q <= LIMIT8, "line position beyond limit")
	`ULRF_ASSERT_NEXT(a_ovf_clears, in_acc && ovf, (fill_q == 8'd0) && (head_q == '0), "overflow did not flush the FIFO")
	`ULRF_ASSERT(a_done_is_cr, !(out_valid && line_done) || (popped_valid && popped_byte == CHAR_CR), "line end without popped carriage return")
	`ULRF_ASSERT(a_stall_needs_s1, !in_stall || s1_valid_q, "input stalled with stage 1 empty")

endmodule

[tb/tb.sv]
// -----------------------------------------------------------------------------
// tb
// Self-checking bench for the line receive FIFO: each word is predicted
// in-bench and every result word is compared field by field, in order.
// -----------------------------------------------------------------------------
module tb;
	import ulrf_pkg::*;

	localparam logic [1:0] CMD_NOP     = 2'd3;   // unused code, status only
	localparam int         CYCLE_LIMIT = 400000;
	localparam int         RANDOM_WORDS = 850;
	localparam int         REPORT_CAP  = 100;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [1:0] command;
	logic [7:0] rx_byte;
	logic       out_valid;
	logic       out_stall;
	logic [7:0] popped_byte;
	logic       popped_valid;
	logic       pop_was_empty;
	logic       overflow_flush;
	logic [7:0] fill_level;
	logic       byte_ready;
	logic [7:0] lines_pending;
	logic       line_ready;
	logic       kept_in_line;
	logic       line_done;
	logic [7:0] line_length;

	uart_line_receive_fifo u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.command        (command),
		.rx_byte        (rx_byte),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.popped_byte    (popped_byte),
		.popped_valid   (popped_valid),
		.pop_was_empty  (pop_was_empty),
		.overflow_flush (overflow_flush),
		.fill_level     (fill_level),
		.byte_ready     (byte_ready),
		.lines_pending  (lines_pending),
		.line_ready     (line_ready),
		.kept_in_line   (kept_in_line),
		.line_done      (line_done),
		.line_length    (line_length)
	);

	// bench copy of the FIFO state
	logic [7:0] ring_copy [FIFO_CAPACITY];
	int         ring_head;
	int         ring_fill;
	int         cr_held;
	int         line_pos;

	result_t    expected_status[$];

	// idling knobs: max wait per word on each side
	int         gap_max;
	int         stall_max;
	int         hold_request;   // long receiver hold-off, picked up by receiver
	int         results_seen;
	int         error_count;
	int         cycle_count;

	// run statistics
	int         words_sent;
	int         pops_done;
	int         empty_pops;
	int         overflows;
	int         lines_ended;
	int         line_full_drops;
	int         input_stalls;

	always #5 clk = ~clk;

	// -------------------------------------------------------------------------
	// predictor
	// -------------------------------------------------------------------------
	function automatic void clear_fifo_copy();
		ring_head = 0;
		ring_fill = 0;
		cr_held   = 0;
		line_pos  = 0;
	endfunction

	function automatic result_t predict_fifo_word(logic [1:0] cmd, logic [7:0] b);
		result_t r;
		logic    ended;
		r     = '0;
		ended = 1'b0;
		case (cmd)
			CMD_RECEIVE: begin
				if (ring_fill < FIFO_CAPACITY) begin
					if (b == CHAR_CR)
						cr_held++;
					// line feeds never reach the store
					if (b != CHAR_LF) begin
						ring_copy[(ring_head + ring_fill) % FIFO_CAPACITY] = b;
						ring_fill++;
					end
				end
				if (ring_fill >= FIFO_CAPACITY) begin
					r.overflow_flush = 1'b1;
					clear_fifo_copy();
				end
			end
			CMD_POP: begin
				if (ring_fill == 0) begin
					r.pop_was_empty = 1'b1;
				end else begin
					r.popped_byte  = ring_copy[ring_head];
					r.popped_valid = 1'b1;
					ring_head = (ring_head + 1) % FIFO_CAPACITY;
					ring_fill--;
					if (r.popped_byte == CHAR_CR) begin
						if (cr_held > 0)
							cr_held--;
						r.line_done = 1'b1;
						ended       = 1'b1;
					end
					if (r.popped_byte > PRINT_MIN && line_pos < LINE_LIMIT) begin
						line_pos++;
						r.kept_in_line = 1'b1;
					end
				end
			end
			CMD_FLUSH: begin
				clear_fifo_copy();
			end
			default: begin
				// no-op, status only
			end
		endcase
		r.fill_level    = 8'(ring_fill);
		r.byte_ready    = (ring_fill > 0);
		r.lines_pending = 8'(cr_held);
		r.line_ready    = (cr_held > 0);
		// the pop that ends a line reports that line's length
		r.line_length   = 8'(line_pos);
		if (ended)
			line_pos = 0;
		return r;
	endfunction

	// -------------------------------------------------------------------------
	// reporting and checking
	// -------------------------------------------------------------------------
	task automatic report_mismatch(string what);
		if (error_count < REPORT_CAP)
			$display("tb: MISMATCH at cycle %0d: %s", cycle_count, what);
		error_count++;
	endtask

	task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %h want %h", name, got, want));
	endtask

	// one result word per accepting edge, compared against oldest prediction
	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid === 1'b1 && !out_stall) begin
			results_seen++;
			if (expected_status.size() == 0) begin
				report_mismatch("result word with nothing outstanding");
			end else begin
				want = expected_status.pop_front();
				check_field("popped_byte",    popped_byte,    want.popped_byte);
				check_field("popped_valid",   8'(popped_valid),   8'(want.popped_valid));
				check_field("pop_was_empty",  8'(pop_was_empty),  8'(want.pop_was_empty));
				check_field("overflow_flush", 8'(overflow_flush), 8'(want.overflow_flush));
				check_field("fill_level",     fill_level,     want.fill_level);
				check_field("byte_ready",     8'(byte_ready),     8'(want.byte_ready));
				check_field("lines_pending",  lines_pending,  want.lines_pending);
				check_field("line_ready",     8'(line_ready),     8'(want.line_ready));
				check_field("kept_in_line",   8'(kept_in_line),   8'(want.kept_in_line));
				check_field("line_done",      8'(line_done),      8'(want.line_done));
				check_field("line_length",    line_length,    want.line_length);
			end
		end
	end

	// receiver: random stall after each taken word, plus long hold-offs
	always @(negedge clk) begin
		static int hold_left  = 0;
		static int stall_left = 0;
		static int last_seen  = 0;
		if (hold_request > 0) begin
			hold_left    = hold_request;
			hold_request = 0;
		end
		if (results_seen != last_seen) begin
			last_seen  = results_seen;
			stall_left = $urandom_range(0, stall_max);
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: timeout after %0d cycles", cycle_count);
			$display("tb: failure");
			$finish;
		end
	end

	// -------------------------------------------------------------------------
	// sender
	// -------------------------------------------------------------------------
	task automatic send_word(logic [1:0] cmd, logic [7:0] b);
		int      gap;
		result_t r;
		@(negedge clk);
		gap = $urandom_range(0, gap_max);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		command  <= cmd;
		rx_byte  <= b;
		do begin
			@(posedge clk);
			if (in_stall)
				input_stalls++;
		end while (in_stall);
		r = predict_fifo_word(cmd, b);
		expected_status.push_back(r);
		words_sent++;
		if (cmd == CMD_POP) begin
			pops_done++;
			if (r.pop_was_empty)
				empty_pops++;
			if (r.line_done)
				lines_ended++;
			if (r.popped_valid && r.popped_byte > PRINT_MIN && !r.kept_in_line)
				line_full_drops++;
		end
		if (r.overflow_flush)
			overflows++;
	endtask

	// sender pauses until every prediction has been matched
	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_status.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [7:0] printable_byte();
		return 8'($urandom_range(8'h1A, 8'hFF));
	endfunction

	// -------------------------------------------------------------------------
	// tests
	// -------------------------------------------------------------------------

	// field extremes, every command, pop on empty, line ending
	task automatic test_directed();
		gap_max   = 0;
		stall_max = 0;
		send_word(CMD_POP,     8'h00);   // empty pop
		send_word(CMD_FLUSH,   8'hFF);
		send_word(CMD_NOP,     8'hFF);
		send_word(CMD_RECEIVE, CHAR_LF); // dropped on an empty FIFO
		send_word(CMD_RECEIVE, 8'h00);
		send_word(CMD_RECEIVE, 8'hFF);
		send_word(CMD_RECEIVE, PRINT_MIN);
		send_word(CMD_RECEIVE, 8'h1A);
		send_word(CMD_RECEIVE, CHAR_CR);
		send_word(CMD_RECEIVE, CHAR_LF);
		send_word(CMD_NOP,     8'h00);
		repeat (5) send_word(CMD_POP, 8'hFF);  // 0x19 not kept, CR ends line
		send_word(CMD_POP,     8'h00);          // empty again
		send_word(CMD_RECEIVE, 8'h41);
		send_word(CMD_RECEIVE, CHAR_CR);
		send_word(CMD_FLUSH,   8'h00);          // clears pending line too
		send_word(CMD_POP,     8'h00);
		send_word(CMD_RECEIVE, CHAR_CR);
		send_word(CMD_POP,     8'h00);          // bare CR: line of length 0
		wait_drained();
	endtask

	// fill to one below capacity, show an LF does not overflow, then overflow
	task automatic fill_to_overflow();
		logic [7:0] b;
		send_word(CMD_FLUSH, 8'h00);
		repeat (FIFO_CAPACITY - 1) begin
			b = 8'($urandom_range(0, 255));
			if (b == CHAR_LF)
				b = CHAR_CR;
			send_word(CMD_RECEIVE, b);
		end
		send_word(CMD_RECEIVE, CHAR_LF);
		send_word(CMD_RECEIVE, printable_byte());  // reaches capacity
		send_word(CMD_POP, 8'h00);                 // flushed: empty
		wait_drained();
	endtask

	task automatic test_overflow();
		gap_max   = 0;
		stall_max = 0;
		fill_to_overflow();
		gap_max   = 3;
		stall_max = 3;
		fill_to_overflow();
	endtask

	// line assembler saturates at the line limit, CR reports full length
	task automatic test_line_limit();
		gap_max   = 3;
		stall_max = 3;
		send_word(CMD_FLUSH, 8'h00);
		repeat (200) send_word(CMD_RECEIVE, printable_byte());
		repeat (200) send_word(CMD_POP, 8'h00);
		repeat (100) send_word(CMD_RECEIVE, printable_byte());
		repeat (100) send_word(CMD_POP, 8'h00);
		send_word(CMD_RECEIVE, CHAR_CR);
		send_word(CMD_RECEIVE, 8'h41);
		repeat (2) send_word(CMD_POP, 8'h00);
		wait_drained();
	endtask

	// receiver holds off while sender keeps offering: pipeline fills and stalls
	task automatic test_backpressure();
		gap_max      = 0;
		stall_max    = 0;
		hold_request = 60;
		repeat (30) send_word(2'($urandom_range(0, 1)), printable_byte());
		wait_drained();
	endtask

	// mostly well-formed lines with random content, pop bursts, some noise
	task automatic test_random_traffic();
		int target;
		int pick;
		int len;
		target = words_sent + RANDOM_WORDS;
		while (words_sent < target) begin
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				len = $urandom_range(0, 30);
				if (ring_fill + len + 2 >= FIFO_CAPACITY - 4) begin
					repeat (len + 10) send_word(CMD_POP, 8'h00);
				end else begin
					repeat (len) begin
						// mostly text, now and then a control byte
						if ($urandom_range(0, 9) == 0)
							send_word(CMD_RECEIVE, 8'($urandom_range(0, 8'h19)));
						else
							send_word(CMD_RECEIVE, printable_byte());
					end
					send_word(CMD_RECEIVE, CHAR_CR);
					if ($urandom_range(0, 1))
						send_word(CMD_RECEIVE, CHAR_LF);
				end
			end else if (pick < 80) begin
				repeat ($urandom_range(1, 40)) send_word(CMD_POP, 8'h00);
			end else if (pick < 92) begin
				send_word(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
			end else if (pick < 94) begin
				send_word(CMD_FLUSH, 8'($urandom_range(0, 255)));
			end else if (pick < 97) begin
				// idling on neither side, on either side or on both
				gap_max   = $urandom_range(0, 1) ? 3 : 0;
				stall_max = $urandom_range(0, 1) ? 3 : 0;
			end else if (pick < 99) begin
				wait_drained();
			end else begin
				hold_request = $urandom_range(10, 40);
			end
		end
		wait_drained();
	endtask

	// -------------------------------------------------------------------------
	// main sequence
	// -------------------------------------------------------------------------
	initial begin
		clk          = 1'b0;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		command      = CMD_RECEIVE;
		rx_byte      = 8'h00;
		out_stall    = 1'b0;
		gap_max      = 3;
		stall_max    = 3;
		hold_request = 0;
		results_seen = 0;
		error_count  = 0;
		cycle_count  = 0;
		words_sent   = 0;
		pops_done    = 0;
		empty_pops   = 0;
		overflows    = 0;
		lines_ended  = 0;
		line_full_drops = 0;
		input_stalls = 0;
		for (int i = 0; i < FIFO_CAPACITY; i++)
			ring_copy[i] = 8'h00;
		clear_fifo_copy();

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_overflow();
		test_line_limit();
		test_backpressure();
		test_random_traffic();

		// let the two register stages settle, catch any stray result words
		repeat (8) @(posedge clk);
		if (expected_status.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", expected_status.size()));

		$display("tb: %0d words, %0d pops (%0d empty), %0d lines ended, %0d overflows",
			words_sent, pops_done, empty_pops, lines_ended, overflows);
		$display("tb: %0d bytes past line limit, %0d input stall cycles, %0d mismatches",
			line_full_drops, input_stalls, error_count);
		if (error_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

[filelist.f]
+incdir+rtl
rtl/ulrf_pkg.sv
rtl/uart_line_receive_fifo.sv
tb/tb.sv
